/* sv/gba_pkg.sv */
package gba_pkg;

    localparam int GROUP_COUNT      = 16;
    localparam int GROUP_BLOCKS     = 32768;
    localparam int WORD_BITS        = 32;
    localparam int WORDS_PER_GROUP  = GROUP_BLOCKS / WORD_BITS;

    localparam int GROUP_W = $clog2(GROUP_COUNT);
    localparam int BIT_W   = $clog2(GROUP_BLOCKS);
    localparam int WIDX_W  = $clog2(WORDS_PER_GROUP);
    localparam int BOFS_W  = $clog2(WORD_BITS);
    localparam int ADDR_W  = GROUP_W + WIDX_W;
    localparam int DEPTH   = GROUP_COUNT * WORDS_PER_GROUP;
    localparam int LIMIT_W = BIT_W + 1;
    localparam int LIVE_W  = GROUP_W + 1;

    localparam int OP_W    = 2;
    localparam int BLOCK_W = 19;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 3;
    localparam int TOTAL_W = 20;

    localparam logic [OP_W-1:0] OP_ALLOC      = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE       = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_WORD  = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD_COUNT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_CORRUPT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FREE     = 3'd4;

    localparam logic [0:0] CFG_FIRST_DATA = 1'b0;
    localparam logic [0:0] CFG_TOTAL      = 1'b1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] GROUP_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic               first_data;
        logic [TOTAL_W-1:0] total_blocks;
        logic [LIVE_W-1:0]  live_groups;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               in_range;
        logic [GROUP_W-1:0] grp;
        logic [BIT_W-1:0]   bitpos;
        logic [ADDR_W-1:0]  word_addr;
        logic [VALUE_W-1:0] word_value;
        logic [COUNT_W-1:0] free_count;
    } cmd_t;

endpackage

/* sv/gba_if.sv */
interface gba_req_if;
    import gba_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [BLOCK_W-1:0] block_number;
    logic [3:0]         group_index;
    logic [9:0]         word_index;
    logic [VALUE_W-1:0] word_value;
    logic [COUNT_W-1:0] free_count;
    modport source (output valid, opcode, block_number, group_index, word_index,
                    word_value, free_count, input ready);
    modport sink (input valid, opcode, block_number, group_index, word_index,
                  word_value, free_count, output ready);
endinterface

interface gba_rsp_if;
    import gba_pkg::*;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [BLOCK_W-1:0] allocated_block;
    logic [TOTAL_W-1:0] total_free;
    modport source (output valid, status, allocated_block, total_free, input ready);
    modport sink (input valid, status, allocated_block, total_free, output ready);
endinterface

/* sv/gba_front.sv */
module gba_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [19:0]             cfg_data,
    gba_req_if.sink                 req,
    output gba_pkg::cfg_t           cfg,
    output logic                    push,
    output gba_pkg::cmd_t           push_cmd,
    input  logic                    push_ready
);
    import gba_pkg::*;

    logic               first_data_reg;
    logic [TOTAL_W-1:0] total_blocks_reg;
    logic [TOTAL_W-1:0] span;
    logic [TOTAL_W:0]   span_up;
    logic [TOTAL_W-BIT_W:0] n_groups;
    logic [BLOCK_W-1:0] rel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_data_reg   <= 1'b0;
            total_blocks_reg <= 20'd524288;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_DATA: first_data_reg <= cfg_data[0];
                CFG_TOTAL:      total_blocks_reg <= cfg_data[TOTAL_W-1:0];
                default:        ;
            endcase
        end
    end

    // live groups = ceil((total - first) / group size), capped
    always_comb
    begin
        span     = total_blocks_reg - {{(TOTAL_W-1){1'b0}}, first_data_reg};
        span_up  = {1'b0, span} + (TOTAL_W+1)'(GROUP_BLOCKS - 1);
        n_groups = span_up[TOTAL_W:BIT_W];
        cfg.first_data   = first_data_reg;
        cfg.total_blocks = total_blocks_reg;
        if (total_blocks_reg <= {{(TOTAL_W-1){1'b0}}, first_data_reg})
            cfg.live_groups = '0;
        else if (n_groups > (TOTAL_W-BIT_W+1)'(GROUP_COUNT))
            cfg.live_groups = LIVE_W'(GROUP_COUNT);
        else
            cfg.live_groups = LIVE_W'(n_groups);
    end

    always_comb
    begin
        rel = req.block_number - {{(BLOCK_W-1){1'b0}}, first_data_reg};
        push_cmd.op       = req.opcode;
        push_cmd.in_range = (req.block_number >= {{(BLOCK_W-1){1'b0}}, first_data_reg}) &&
                            ({1'b0, req.block_number} < total_blocks_reg);
        push_cmd.grp        = rel[BLOCK_W-1:BIT_W];
        push_cmd.bitpos     = rel[BIT_W-1:0];
        push_cmd.word_addr  = {req.group_index, req.word_index};
        push_cmd.word_value = req.word_value;
        push_cmd.free_count = req.free_count;
    end

    assign req.ready = push_ready;
    assign push      = req.valid && push_ready;

endmodule

/* sv/gba_queue.sv */
module gba_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gba_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output gba_pkg::cmd_t pop_cmd,
    output logic          pop_valid
);
    import gba_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

/* sv/gba_back.sv */
module gba_back (
    input  logic          clk,
    input  logic          rst_n,
    input  gba_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  gba_pkg::cmd_t q_cmd,
    output logic          q_pop,
    gba_rsp_if.source     rsp
);
    import gba_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FREE_RD  = 3'd1;
    localparam logic [2:0] S_FREE_CHK = 3'd2;
    localparam logic [2:0] S_GSTART   = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_CHK      = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    logic [2:0]         state_reg;
    cmd_t               cmd_reg;
    logic [GROUP_W-1:0] g_reg;
    logic [WIDX_W-1:0]  w_reg;
    logic [BIT_W-1:0]   start_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               goal_phase_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [BLOCK_W-1:0] blk_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [COUNT_W-1:0] group_free_reg [GROUP_COUNT];

    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [BLOCK_W-1:0] out_blk_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;

    logic [TOTAL_W-1:0] g_start;
    logic [TOTAL_W-1:0] g_remain;
    logic [LIMIT_W-1:0] limit_calc;
    logic [BIT_W-1:0]   base;
    logic [LIMIT_W-1:0] rem;
    logic [WORD_BITS-1:0] mask_lo;
    logic [WORD_BITS-1:0] mask_hi;
    logic [WORD_BITS-1:0] cand;
    logic [BOFS_W-1:0]  first_zero;
    logic [LIVE_W-1:0]  g_plus;
    logic               out_free;

    assign rd_addr = (state_reg == S_FREE_RD) ?
                     {cmd_reg.grp, cmd_reg.bitpos[BIT_W-1:BOFS_W]} : {g_reg, w_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // group limit = min(total - group start, group size)
    always_comb
    begin
        g_start  = TOTAL_W'({g_reg, {BIT_W{1'b0}}}) + TOTAL_W'(cfg.first_data);
        g_remain = cfg.total_blocks - g_start;
        if (g_remain < TOTAL_W'(GROUP_BLOCKS))
            limit_calc = g_remain[LIMIT_W-1:0];
        else
            limit_calc = LIMIT_W'(GROUP_BLOCKS);
    end

    always_comb
    begin
        base = {w_reg, {BOFS_W{1'b0}}};
        rem  = limit_reg - {1'b0, base};
        if (w_reg == start_reg[BIT_W-1:BOFS_W])
            mask_lo = {WORD_BITS{1'b1}} << start_reg[BOFS_W-1:0];
        else
            mask_lo = {WORD_BITS{1'b1}};
        if (rem >= LIMIT_W'(WORD_BITS))
            mask_hi = {WORD_BITS{1'b1}};
        else
            mask_hi = ~({WORD_BITS{1'b1}} << rem[BOFS_W-1:0]);
        cand = ~rd_data_reg & mask_lo & mask_hi;
        first_zero = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
                first_zero = BOFS_W'(i);
        end
        g_plus = {1'b0, g_reg} + LIVE_W'(1);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {g_reg, w_reg};
        wr_data = rd_data_reg | (WORD_BITS'(1) << first_zero);
        if (state_reg == S_IDLE && q_valid && q_cmd.op == OP_LOAD_WORD)
        begin
            wr_en   = 1'b1;
            wr_addr = q_cmd.word_addr;
            wr_data = q_cmd.word_value;
        end
        else if (state_reg == S_CHK && cand != '0)
            wr_en = 1'b1;
        else if (state_reg == S_FREE_CHK && rd_data_reg[cmd_reg.bitpos[BOFS_W-1:0]])
        begin
            wr_en   = 1'b1;
            wr_addr = {cmd_reg.grp, cmd_reg.bitpos[BIT_W-1:BOFS_W]};
            wr_data = rd_data_reg & ~(WORD_BITS'(1) << cmd_reg.bitpos[BOFS_W-1:0]);
        end
    end

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            goal_phase_reg <= 1'b0;
            for (int i = 0; i < GROUP_COUNT; i++)
                group_free_reg[i] <= '0;
        end
        else
        begin
            if (rsp.ready && !(state_reg == S_DONE && out_free))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg    <= q_cmd;
                        status_reg <= ST_OK;
                        blk_reg    <= '0;
                        state_reg  <= S_DONE;
                        case (q_cmd.op)
                            OP_ALLOC:
                            begin
                                if (q_cmd.in_range)
                                begin
                                    g_reg          <= q_cmd.grp;
                                    start_reg      <= q_cmd.bitpos;
                                    goal_phase_reg <= 1'b1;
                                    state_reg      <= S_GSTART;
                                end
                                else
                                begin
                                    g_reg          <= '0;
                                    start_reg      <= '0;
                                    goal_phase_reg <= 1'b0;
                                    if (cfg.live_groups == '0)
                                        status_reg <= ST_NOSPACE;
                                    else
                                        state_reg <= S_GSTART;
                                end
                            end
                            OP_FREE:
                            begin
                                if (q_cmd.in_range)
                                    state_reg <= S_FREE_RD;
                                else
                                    status_reg <= ST_RANGE;
                            end
                            OP_LOAD_COUNT:
                            begin
                                group_free_reg[q_cmd.word_addr[ADDR_W-1:WIDX_W]] <=
                                    q_cmd.free_count;
                                if ({1'b0, total_reg} + (TOTAL_W+1)'(q_cmd.free_count) >
                                    (TOTAL_W+1)'(TOTAL_MAX))
                                    total_reg <= TOTAL_MAX;
                                else
                                    total_reg <= total_reg + TOTAL_W'(q_cmd.free_count);
                            end
                            default: ;
                        endcase
                    end
                end
                S_FREE_RD:
                    state_reg <= S_FREE_CHK;
                S_FREE_CHK:
                begin
                    state_reg <= S_DONE;
                    if (!rd_data_reg[cmd_reg.bitpos[BOFS_W-1:0]])
                        status_reg <= ST_FREE;
                    else
                    begin
                        if (group_free_reg[cmd_reg.grp] != GROUP_MAX)
                            group_free_reg[cmd_reg.grp] <= group_free_reg[cmd_reg.grp] + 1'b1;
                        if (total_reg != TOTAL_MAX)
                            total_reg <= total_reg + 1'b1;
                    end
                end
                S_GSTART, S_CHK:
                begin
                    if (state_reg == S_GSTART && group_free_reg[g_reg] != '0)
                    begin
                        limit_reg <= limit_calc;
                        w_reg     <= start_reg[BIT_W-1:BOFS_W];
                        state_reg <= S_SCAN;
                    end
                    else if (state_reg == S_CHK && cand != '0)
                    begin
                        group_free_reg[g_reg] <= group_free_reg[g_reg] - 1'b1;
                        if (total_reg != '0)
                            total_reg <= total_reg - 1'b1;
                        blk_reg   <= BLOCK_W'({g_reg, w_reg, first_zero}) +
                                     BLOCK_W'(cfg.first_data);
                        state_reg <= S_DONE;
                    end
                    else if (state_reg == S_CHK && rem > LIMIT_W'(WORD_BITS))
                    begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                    else if (state_reg == S_CHK && start_reg == '0)
                    begin
                        status_reg <= ST_CORRUPT;
                        state_reg  <= S_DONE;
                    end
                    // nothing here: leave the goal group for group 0, else move on to the next group or report no space
                    else if (goal_phase_reg)
                    begin
                        goal_phase_reg <= 1'b0;
                        g_reg          <= '0;
                        start_reg      <= '0;
                        state_reg      <= S_GSTART;
                    end
                    else if (g_plus < cfg.live_groups)
                    begin
                        g_reg     <= g_plus[GROUP_W-1:0];
                        start_reg <= '0;
                        state_reg <= S_GSTART;
                    end
                    else
                    begin
                        status_reg <= ST_NOSPACE;
                        state_reg  <= S_DONE;
                    end
                end
                S_SCAN:
                    state_reg <= S_CHK;
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_blk_reg    <= (status_reg == ST_OK) ? blk_reg : '0;
                        out_total_reg  <= total_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.allocated_block = out_blk_reg;
    assign rsp.total_free      = out_total_reg;

endmodule

/* sv/grouped_bitmap_block_allocator_unit.sv */
// Grouped bitmap block allocator.
// Channels: req (valid/ready) carries one operation: allocate near a goal,
// free a block, load a bitmap word or load a group free count. rsp carries
// one result per operation: status, allocated block, total free count.
// cfg_we/cfg_index/cfg_data set first data block (0) and total blocks (1);
// write them only while no operation is in flight.
// The front end decodes and range checks each request and pushes it into a
// two-entry queue; the back end executes one operation at a time.
// The allocation scan reads one bitmap word at a time through the registered
// bitmap memory read and visits the groups in turn; a free reads its bitmap
// word before it clears the bit. Up to two requests queue while the back
// end works.
// Reset clears group counts, total count and control; bitmap memory is not
// cleared and must be loaded before use.
// When rsp stalls, the result waits in the output register; the back end
// holds its next result and the queue keeps accepting until full.
module grouped_bitmap_block_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_data,
    gba_req_if.sink     req,
    gba_rsp_if.source   rsp
);
    import gba_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic push_ready;
    logic pop;
    logic pop_valid;

    gba_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .cfg        (cfg),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    gba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid)
    );

    gba_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (pop_valid),
        .q_cmd   (pop_cmd),
        .q_pop   (pop),
        .rsp     (rsp)
    );

endmodule
